>>> hdl/looping_sample_resampler_macros.svh
// Assertion macros shared by the resampler RTL.
`ifndef LOOPING_SAMPLE_RESAMPLER_MACROS_SVH
`define LOOPING_SAMPLE_RESAMPLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lsr_pkg.sv
// Shared constants and types for the looping sample resampler.
package lsr_pkg;

  // Sample memory geometry
  localparam int SAMPLE_DEPTH = 65536;
  localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);

  // Item field widths
  localparam int CMD_W    = 2;
  localparam int WADDR_W  = 16;
  localparam int BYTE_W   = 8;
  localparam int PERIOD_W = 11;

  // Register widths
  localparam int RATE_W   = 18;
  localparam int LEN_W    = 16;
  localparam int DIST_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = RATE_W;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 11'd2047;

  // Step arithmetic: increment = INC_NUM / (period * rate)
  localparam int DEN_W   = PERIOD_W + RATE_W;
  localparam int QUO_W   = 38;
  localparam logic [QUO_W-1:0] INC_NUM = 38'd214552320000;
  localparam int FRAC_W  = 16;
  localparam int SUM_W   = QUO_W + 1;
  localparam int CARRY_W = SUM_W - FRAC_W;
  localparam int POS_W   = ((ADDR_W > CARRY_W) ? ADDR_W : CARRY_W) + 1;
  localparam int CNT_W   = $clog2(QUO_W + 1);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FRAME = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_DIST   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_EN     = 2'd3;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hdl/lsr_sample_ram.sv
// Sample byte memory: one write port, one registered read port.
module lsr_sample_ram
  import lsr_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [SAMPLE_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/lsr_divider.sv
// Restoring divider: constant step numerator over a runtime divisor, one bit per cycle.
module lsr_divider
  import lsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DEN_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [QUO_W-1:0] quotient
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] count_r;
  logic [DEN_W-1:0] divisor_r;
  logic             zero_r;
  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] quo_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // One trial subtraction per cycle
  assign trial = {rem_r, quo_r[QUO_W-1]};
  assign diff  = trial - {1'b0, divisor_r};
  assign fits  = trial >= {1'b0, divisor_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r  <= 1'b1;
        count_r <= CNT_W'(QUO_W);
      end else if (busy_r) begin
        count_r <= count_r - 1'b1;
        if (count_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient register starts as the numerator and shifts out its bits
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      divisor_r <= divisor;
      zero_r    <= (divisor == '0);
      rem_r     <= '0;
      quo_r     <= INC_NUM;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], fits};
    end
  end

  // Zero divisor gives a zero step
  assign quotient  = zero_r ? '0 : quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> hdl/looping_sample_resampler.sv
// Looping sample resampler. Write items (cmd 0) store a byte in the 64K sample
// memory and start items (cmd 1) rewind the voice; both give no result. A frame
// item (cmd 2) on a playing voice steps through the period-times-rate product
// and the sample read, the bit-serial divider that forms the step and its done
// flag, then the fraction add and the position update/end check, which also
// loads the result register. A frame on an idle voice returns zero in the next
// cycle. The input stalls while an item is in progress and while a result
// waits to be taken. Configuration writes are always taken and should be made
// while idle.
`include "looping_sample_resampler_macros.svh"

module looping_sample_resampler
  import lsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [WADDR_W-1:0]    in_write_address,
  input  logic [BYTE_W-1:0]     in_write_byte,
  input  logic [PERIOD_W-1:0]   in_pitch_period,
  // Result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_frame_byte,
  output logic                  out_still_playing,
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_SUM  = 6'b001000,
    ST_POS  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;

  logic [RATE_W-1:0]   rate_r;
  logic [LEN_W-1:0]    len_r;
  logic [DIST_W-1:0]   loop_dist_r;
  logic                loop_en_r;

  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [FRAC_W-1:0]   frac_r;
  logic                active_r, active_nxt;
  logic [PERIOD_W-1:0] period_r;
  logic [SUM_W-1:0]    sum_r;
  logic [BYTE_W-1:0]   frame_byte_r;

  logic                in_accept;
  logic                out_accept;
  logic [PERIOD_W-1:0] period_sat;
  logic [DEN_W-1:0]    product;
  logic [POS_W-1:0]    pos_sum;
  logic                past_end;

  div_stat_t           div_stat;
  logic [QUO_W-1:0]    div_quo;
  logic [BYTE_W-1:0]   ram_rd_data;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = (state_r == ST_OUT);
  assign cfg_ready  = 1'b1;

  // Period clamp and the divisor product
  assign period_sat = (in_pitch_period > PERIOD_MAX) ? PERIOD_MAX : in_pitch_period;
  assign product    = DEN_W'(period_r) * DEN_W'(rate_r);

  lsr_sample_ram u_ram (
    .clk     (clk),
    .wr_en   (in_accept && (in_cmd == CMD_WRITE)),
    .wr_addr (ADDR_W'(in_write_address)),
    .wr_data (in_write_byte),
    .rd_en   (state_r == ST_MUL),
    .rd_addr (pos_r),
    .rd_data (ram_rd_data)
  );

  lsr_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_MUL),
    .divisor  (product),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // Position update with end-of-sample handling; end test before the wrap
  assign pos_sum  = POS_W'(pos_r) + POS_W'(sum_r[SUM_W-1:FRAC_W]);
  assign past_end = pos_sum > POS_W'(len_r);

  always_comb begin
    pos_nxt    = pos_sum[ADDR_W-1:0];
    active_nxt = active_r;
    if (past_end) begin
      if (loop_en_r) begin
        pos_nxt = pos_sum[ADDR_W-1:0] - ADDR_W'(loop_dist_r);
      end else begin
        active_nxt = 1'b0;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_cmd == CMD_FRAME)) begin
          state_nxt = active_r ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM:  state_nxt = ST_POS;
      ST_POS:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_accept) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= RATE_W'(48000);
      len_r       <= '0;
      loop_dist_r <= '0;
      loop_en_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OUTPUT_RATE: rate_r      <= cfg_data[RATE_W-1:0];
        REG_LENGTH:      len_r       <= cfg_data[LEN_W-1:0];
        REG_LOOP_DIST:   loop_dist_r <= cfg_data[DIST_W-1:0];
        REG_LOOP_EN:     loop_en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Voice state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      frac_r   <= '0;
      active_r <= 1'b0;
    end else if (in_accept && (in_cmd == CMD_START)) begin
      pos_r    <= '0;
      frac_r   <= '0;
      active_r <= 1'b1;
    end else if (state_r == ST_POS) begin
      pos_r    <= pos_nxt;
      frac_r   <= sum_r[FRAC_W-1:0];
      active_r <= active_nxt;
    end
  end

  // Per-frame payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      period_r <= period_sat;
    end
    if (state_r == ST_SUM) begin
      sum_r <= SUM_W'(frac_r) + SUM_W'(div_quo);
    end
    if (in_accept && (in_cmd == CMD_FRAME) && !active_r) begin
      frame_byte_r <= '0;
    end else if (state_r == ST_POS) begin
      frame_byte_r <= ram_rd_data;
    end
  end

  assign out_frame_byte    = frame_byte_r;
  assign out_still_playing = active_r;

  `LSR_ASSERT_NOW(a_busy_stalls, state_r != ST_IDLE, in_stall, "input taken while busy")
  `LSR_ASSERT_NOW(a_div_done_in_wait, div_stat.done, state_r == ST_DIV, "divider done outside wait")
  `LSR_ASSERT_NEXT(a_idle_frame_zero,
    in_accept && (in_cmd == CMD_FRAME) && !active_r,
    out_valid && (out_frame_byte == '0) && !out_still_playing,
    "idle frame result not zero")
  `LSR_ASSERT_NEXT(a_stop_at_end, (state_r == ST_POS) && past_end && !loop_en_r,
    !active_r && out_valid, "voice did not stop at sample end")

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the looping sample resampler.
`timescale 1ns / 100ps

module tb_top;
  import lsr_pkg::*;

  // Command code the block ignores
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  localparam longint unsigned STEP_NUM = 64'd214552320000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 83;
  localparam int NUM_PHASES    = 7;
  localparam longint TIMEOUT_NS = 64'd5_000_000;

  typedef struct packed {
    logic [BYTE_W-1:0] sample;
    logic              playing;
  } frame_t;

  // One line of the directed plan: a register write or an item
  typedef struct packed {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [CMD_W-1:0]      cmd;
    logic [WADDR_W-1:0]    addr;
    logic [BYTE_W-1:0]     wbyte;
    logic [PERIOD_W-1:0]   period;
    bit                    typed;
    frame_t                want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_cmd = CMD_NONE;
  logic [WADDR_W-1:0]    in_write_address = '0;
  logic [BYTE_W-1:0]     in_write_byte = '0;
  logic [PERIOD_W-1:0]   in_pitch_period = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_frame_byte;
  logic                  out_still_playing;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  looping_sample_resampler i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_write_address  (in_write_address),
    .in_write_byte     (in_write_byte),
    .in_pitch_period   (in_pitch_period),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_byte    (out_frame_byte),
    .out_still_playing (out_still_playing),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Voice model: sample memory, phase accumulator and register copies
  logic [BYTE_W-1:0]   voice_mem [SAMPLE_DEPTH];
  bit                  mem_set [SAMPLE_DEPTH];
  logic [ADDR_W-1:0]   play_pos = '0;
  logic [FRAC_W-1:0]   play_frac = '0;
  bit                  voice_on = 1'b0;
  logic [RATE_W-1:0]   rate_q = 18'd48000;
  logic [LEN_W-1:0]    len_q = '0;
  logic [DIST_W-1:0]   loop_dist_q = '0;
  bit                  loop_q = 1'b0;

  frame_t    frames_due[$];
  plan_row_t plan[$];

  // Run control and statistics
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int wait_left = 0;
  int n_errors = 0;
  int n_items = 0;
  int n_frames = 0;
  int n_writes = 0;
  int n_starts = 0;
  int n_regs = 0;
  int n_wraps = 0;
  int n_ends = 0;

  // Phase step for one frame; a zero product gives no motion
  function automatic longint unsigned step_for(input logic [PERIOD_W-1:0] period);
    longint unsigned den;
    den = 64'(period) * 64'(rate_q);
    if (den == 0) return 0;
    return STEP_NUM / den;
  endfunction

  // Output of one frame, then advance the voice
  function automatic frame_t next_frame(input logic [PERIOD_W-1:0] period);
    frame_t res;
    longint unsigned sum;
    longint unsigned pos;
    res.sample = '0;
    if (voice_on) begin
      res.sample = voice_mem[play_pos];
      sum = 64'(play_frac) + step_for(period);
      pos = 64'(play_pos) + (sum >> FRAC_W);
      play_frac = sum[FRAC_W-1:0];
      // end test on the unwrapped position
      if (pos > 64'(len_q)) begin
        if (loop_q) begin
          pos = (pos % SAMPLE_DEPTH + SAMPLE_DEPTH - 64'(loop_dist_q)) % SAMPLE_DEPTH;
          n_wraps++;
        end else begin
          voice_on = 1'b0;
          n_ends++;
        end
      end
      play_pos = pos[ADDR_W-1:0];
    end
    res.playing = voice_on;
    return res;
  endfunction

  function automatic void plan_item(input logic [CMD_W-1:0] cmd,
                                    input logic [WADDR_W-1:0] addr = '0,
                                    input logic [BYTE_W-1:0] wb = '0,
                                    input logic [PERIOD_W-1:0] period = '0,
                                    input bit typed = 1'b0,
                                    input logic [BYTE_W-1:0] sample = '0,
                                    input logic playing = 1'b0);
    plan_row_t r;
    r = '0;
    r.cmd = cmd;
    r.addr = addr;
    r.wbyte = wb;
    r.period = period;
    r.typed = typed;
    r.want.sample = sample;
    r.want.playing = playing;
    plan.push_back(r);
  endfunction

  function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    plan.push_back(r);
  endfunction

  // Present one item and hold it until the block takes it
  task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [WADDR_W-1:0] addr,
                            input logic [BYTE_W-1:0] wb, input logic [PERIOD_W-1:0] period);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_write_address <= addr;
    in_write_byte <= wb;
    in_pitch_period <= period;
    do @(posedge clk); while (in_stall);
  endtask

  // Predict one item, queue its frame if any, then send it
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [WADDR_W-1:0] addr,
                       input logic [BYTE_W-1:0] wb, input logic [PERIOD_W-1:0] period,
                       input bit typed = 1'b0, input frame_t want = '0);
    logic [ADDR_W-1:0] fill_addr;
    logic [BYTE_W-1:0] fill_byte;
    frame_t res;
    // never let a frame read a memory slot that was not written
    if (cmd == CMD_FRAME && voice_on && !mem_set[play_pos]) begin
      fill_addr = play_pos;
      fill_byte = BYTE_W'($urandom);
      voice_mem[fill_addr] = fill_byte;
      mem_set[fill_addr] = 1'b1;
      n_writes++;
      n_items++;
      offer_item(CMD_WRITE, fill_addr, fill_byte, PERIOD_W'($urandom));
    end
    case (cmd)
      CMD_WRITE: begin
        voice_mem[addr] = wb;
        mem_set[addr] = 1'b1;
        n_writes++;
      end
      CMD_START: begin
        play_pos = '0;
        play_frac = '0;
        voice_on = 1'b1;
        n_starts++;
      end
      CMD_FRAME: begin
        res = next_frame(period);
        frames_due.push_back(typed ? want : res);
      end
      default: ;
    endcase
    if (cmd != CMD_NONE) n_items++;
    offer_item(cmd, addr, wb, period);
  endtask

  // Stop sending, let all frames come back, then let the block settle
  task automatic quiesce();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_OUTPUT_RATE: rate_q = val[RATE_W-1:0];
      REG_LENGTH:      len_q = val[LEN_W-1:0];
      REG_LOOP_DIST:   loop_dist_q = val[DIST_W-1:0];
      REG_LOOP_EN:     loop_q = val[0];
      default: ;
    endcase
    n_regs++;
  endtask

  // Result side: check each frame, stall at random, long hold on request
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_frames++;
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected frame: byte %02h playing %0d", $time,
                 out_frame_byte, out_still_playing);
        n_errors++;
      end else begin
        if (out_frame_byte !== frames_due[0].sample) begin
          $display("%0t: frame byte expected %02h, got %02h", $time,
                   frames_due[0].sample, out_frame_byte);
          n_errors++;
        end
        if (out_still_playing !== frames_due[0].playing) begin
          $display("%0t: playing flag expected %0d, got %0d", $time,
                   frames_due[0].playing, out_still_playing);
          n_errors++;
        end
        void'(frames_due.pop_front());
      end
      wait_left = calm ? 0 : $urandom_range(0, 5);
    end else if (wait_left > 0) begin
      wait_left--;
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (wait_left != 0);
    end
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus
  initial begin
    bit cfg_open;
    int phase;
    int phase_end;
    int unsigned pick;
    logic [PERIOD_W-1:0] period;
    logic [WADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] rate_v;
    logic [CFG_DATA_W-1:0] len_v;
    logic [CFG_DATA_W-1:0] dist_v;
    logic [CFG_DATA_W-1:0] loop_v;

    // Directed plan, first under reset settings (one-shot, length 0)
    plan_item(CMD_FRAME, '0, '0, 11'd1, 1'b1, 8'h00, 1'b0);      // idle voice
    plan_item(CMD_FRAME, '0, '0, 11'd2047, 1'b1, 8'h00, 1'b0);
    plan_item(CMD_NONE, 16'hFFFF, 8'hFF, 11'h7FF);                 // ignored
    plan_item(CMD_WRITE, 16'h0000, 8'h5A);
    plan_item(CMD_WRITE, 16'hFFFF, 8'hFF);
    plan_item(CMD_WRITE, 16'h0001, 8'hA5);
    plan_item(CMD_START);
    plan_item(CMD_FRAME, '0, '0, 11'd0, 1'b1, 8'h5A, 1'b1);       // no step
    plan_item(CMD_FRAME, '0, '0, 11'd2047, 1'b1, 8'h5A, 1'b1);    // sub-sample step
    plan_item(CMD_FRAME, '0, '0, 11'd1, 1'b1, 8'h5A, 1'b0);       // runs off the end
    plan_item(CMD_FRAME, '0, '0, 11'd1, 1'b1, 8'h00, 1'b0);
    // looping with a step back below zero
    plan_reg(REG_LOOP_EN, 18'd1);
    plan_reg(REG_LOOP_DIST, 18'd2);
    plan_reg(REG_LENGTH, 18'd0);
    plan_item(CMD_START);
    plan_item(CMD_FRAME, '0, '0, 11'd68, 1'b1, 8'h5A, 1'b1);
    plan_item(CMD_FRAME, '0, '0, 11'd68, 1'b1, 8'hFF, 1'b1);
    plan_item(CMD_FRAME, '0, '0, 11'd68);
    // zero rate holds the position
    plan_reg(REG_OUTPUT_RATE, 18'd0);
    plan_item(CMD_FRAME, '0, '0, 11'd100);
    plan_item(CMD_FRAME, '0, '0, 11'd1);
    // top rate, full length, full loop distance
    plan_reg(REG_OUTPUT_RATE, 18'h3FFFF);
    plan_reg(REG_LENGTH, 18'd65535);
    plan_reg(REG_LOOP_DIST, 18'd65535);
    plan_item(CMD_START);
    plan_item(CMD_FRAME, '0, '0, 11'd1);
    plan_item(CMD_FRAME, '0, '0, 11'd2047);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    cfg_open = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!cfg_open) begin
          quiesce();
          cfg_open = 1'b1;
        end
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        issue(plan[i].cmd, plan[i].addr, plan[i].wbyte, plan[i].period,
              plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under its own register settings
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      quiesce();
      calm = 1'b0;
      case (phase)
        0: begin
          rate_v = 18'd48000; len_v = 18'd255; dist_v = 18'd200; loop_v = 18'd1;
        end
        1: begin
          rate_v = 18'h3FFFF; len_v = 18'd65535; dist_v = 18'd0; loop_v = 18'd1;
          calm = 1'b1;
        end
        2: begin
          rate_v = 18'd1; len_v = 18'd65535; dist_v = 18'd65535; loop_v = 18'd0;
        end
        3: begin
          rate_v = 18'd8000;
          len_v = CFG_DATA_W'($urandom_range(0, 600));
          dist_v = CFG_DATA_W'($urandom_range(1, 600));
          loop_v = 18'd1;
        end
        4: begin
          rate_v = 18'd200000; len_v = 18'd40; dist_v = 18'd0; loop_v = 18'd0;
        end
        5: begin
          rate_v = CFG_DATA_W'($urandom_range(1, 262143));
          len_v = CFG_DATA_W'($urandom_range(0, 65535));
          dist_v = CFG_DATA_W'($urandom_range(0, 65535));
          loop_v = CFG_DATA_W'($urandom_range(0, 1));
        end
        default: begin
          rate_v = 18'd96000; len_v = 18'd1000; dist_v = 18'd65535; loop_v = 18'd1;
        end
      endcase
      write_reg(REG_OUTPUT_RATE, rate_v);
      write_reg(REG_LENGTH, len_v);
      write_reg(REG_LOOP_DIST, dist_v);
      write_reg(REG_LOOP_EN, loop_v);
      cfg_valid <= 1'b0;
      // the receiver holds off while the sender keeps pushing
      if (phase == 3) hold_req = 1'b1;

      issue(CMD_START, WADDR_W'($urandom), BYTE_W'($urandom), PERIOD_W'($urandom));
      phase_end = n_items + PHASE_ITEMS;
      while (n_items < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 68) begin
          case ($urandom_range(0, 3))
            0: period = PERIOD_W'($urandom_range(0, 80));
            1: period = PERIOD_W'($urandom_range(1500, 2047));
            default: period = PERIOD_W'($urandom);
          endcase
          issue(CMD_FRAME, WADDR_W'($urandom), BYTE_W'($urandom), period);
        end else if (pick < 76) begin
          issue(CMD_START, WADDR_W'($urandom), BYTE_W'($urandom), PERIOD_W'($urandom));
        end else if (pick < 94) begin
          // half the time just ahead of the play position
          if ($urandom_range(0, 1) == 0) addr = play_pos + WADDR_W'($urandom_range(0, 15));
          else addr = WADDR_W'($urandom);
          issue(CMD_WRITE, addr, BYTE_W'($urandom), PERIOD_W'($urandom));
        end else begin
          issue(CMD_NONE, WADDR_W'($urandom), BYTE_W'($urandom), PERIOD_W'($urandom));
        end
      end
    end

    quiesce();
    $display("Run covered %0d items: %0d frames checked, %0d memory writes, %0d starts.",
             n_items, n_frames, n_writes, n_starts);
    $display("%0d register writes over %0d settings; %0d loop-backs, %0d voice ends.",
             n_regs, NUM_PHASES + 4, n_wraps, n_ends);
    if (n_errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/lsr_pkg.sv
hdl/lsr_sample_ram.sv
hdl/lsr_divider.sv
hdl/looping_sample_resampler.sv
dv/tb_top.sv
